### rtl/twd_pkg.sv
package twd_pkg;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 20;

   localparam logic [7:0]        IAC_BYTE   = 8'o377;
   localparam logic [6:0]        ESC_CHAR   = 7'o033;
   localparam logic [6:0]        NUL_CHAR   = 7'o000;
   localparam logic [1:0]        SYNC_MID   = 2'b10;
   localparam logic [1:0]        SYNC_LAST  = 2'b11;
   localparam logic [WORD_W-1:0] ESC_WORD   = 20'(7'o033) << 8;
   localparam logic [WORD_W-1:0] DELAY_WORD = 20'(1) << 19;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_MIDDLE = 2'd1,
      PHASE_LAST   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      PFX_NONE = 2'd0,
      PFX_IAC  = 2'd1,
      PFX_ESC  = 2'd2
   } prefix_type;

   typedef struct packed {
      logic              hit;
      logic [WORD_W-1:0] word;
   } result_type;

endpackage

### rtl/terminal_word_deframer.sv
// Terminal word deframer: takes one received byte per transfer and gives at most one
// terminal word per byte. With csr_ascii_mode low, bytes are three-byte frames (first,
// middle, last, marked by their top bits) that build a 19-bit word; out-of-sync bytes
// are dropped or restart the frame. With csr_ascii_mode high, an IAC with no prefix
// pending is swallowed, ESC makes the next character an escape word and NUL becomes
// the delay word (bit 19). One byte is accepted every cycle while the output is not
// stalled: a byte waits in the input register, is decoded against the frame state and
// lands in the output register once that is free; words are offered from there. The
// output register is the only point of backpressure. Write the mode only while no
// bytes or words are in flight.
module terminal_word_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [twd_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [twd_pkg::WORD_W-1:0]    rsp_term_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_ascii_mode
);
   import twd_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   logic [WORD_W-1:0] out_word_ff;
   logic              mode_ff;
   logic              fire;
   result_type        result;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;
   assign rsp_valid     = out_valid_ff;
   assign rsp_term_word = out_word_ff;

   twd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (fire),
      .ascii_mode (mode_ff),
      .rx_byte    (in_byte_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_ascii_mode;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            out_valid_ff <= result.hit;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (fire && result.hit) begin
         out_word_ff <= result.word;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(out_valid_ff && !rsp_ready))
      else $error("decoded byte would overwrite a waiting word");

   a_word_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(fire))
      else $error("word appeared without a decoded byte");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input byte lost");

   a_delay_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff[WORD_W-1] |-> out_word_ff[WORD_W-2:0] == '0)
      else $error("delay word carries extra bits");

endmodule

### rtl/twd_decode.sv
module twd_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          ascii_mode,
   input  logic [twd_pkg::BYTE_W-1:0]    rx_byte,
   output twd_pkg::result_type           result
);
   import twd_pkg::*;

   phase_type  phase_ff, phase_in;
   prefix_type prefix_ff, prefix_in;
   logic [6:0] first_ff, first_in;
   logic [5:0] middle_ff, middle_in;
   logic [6:0] chr;
   logic       handled;

   assign chr = rx_byte[6:0];

   always_comb begin
      phase_in    = phase_ff;
      prefix_in   = prefix_ff;
      first_in    = first_ff;
      middle_in   = middle_ff;
      result.hit  = 1'b0;
      result.word = '0;
      handled     = 1'b0;
      if (ascii_mode) begin
         if (prefix_ff == PFX_NONE && rx_byte == IAC_BYTE) begin
            // swallow the Telnet command byte
            prefix_in = PFX_IAC;
         end else if (chr == ESC_CHAR) begin
            prefix_in = PFX_ESC;
         end else begin
            prefix_in  = PFX_NONE;
            result.hit = 1'b1;
            if (prefix_ff == PFX_ESC) begin
               result.word = ESC_WORD | WORD_W'(chr);
            end else if (chr == NUL_CHAR) begin
               result.word = DELAY_WORD;
            end else begin
               result.word = WORD_W'(chr);
            end
         end
      end else begin
         case (phase_ff)
            PHASE_MIDDLE: begin
               if (rx_byte[7:6] == SYNC_MID) begin
                  middle_in = rx_byte[5:0];
                  phase_in  = PHASE_LAST;
                  handled   = 1'b1;
               end
            end
            PHASE_LAST: begin
               if (rx_byte[7:6] == SYNC_LAST) begin
                  result.hit  = 1'b1;
                  result.word = {1'b0, first_ff, middle_ff, rx_byte[5:0]};
                  phase_in    = PHASE_FIRST;
                  handled     = 1'b1;
               end
            end
            default: ;
         endcase
         if (!handled) begin
            // top bit clear restarts the frame, anything else is dropped
            if (!rx_byte[7]) begin
               first_in = chr;
               phase_in = PHASE_MIDDLE;
            end else begin
               phase_in = PHASE_FIRST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_FIRST;
         prefix_ff <= PFX_NONE;
         first_ff  <= '0;
         middle_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         prefix_ff <= prefix_in;
         first_ff  <= first_in;
         middle_ff <= middle_in;
      end
   end

   a_esc_needs_char: assert property (@(posedge clock) disable iff (reset)
      step && ascii_mode && result.hit |=> prefix_ff == PFX_NONE)
      else $error("prefix not cleared after an ASCII word");

   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      step && !ascii_mode && result.hit |=> phase_ff == PHASE_FIRST)
      else $error("frame phase not reset after a complete word");

   a_mode_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      step && ascii_mode |=> $stable(phase_ff) && $stable(first_ff))
      else $error("frame state changed in ASCII mode");

endmodule

### bench/tb_terminal_word_deframer.sv
module tb_terminal_word_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import twd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASES       = 8;
   localparam int PHASE_BYTES  = 172;

   typedef enum bit {ROW_BYTE, ROW_MODE} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [7:0]        value;
      bit                known;
      logic [WORD_W-1:0] word;
   } stim_row_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte    = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b1;
   logic [WORD_W-1:0]   rsp_term_word;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic                csr_ascii_mode = 1'b0;

   // shadow of the block state
   logic              ascii_sel    = 1'b0;
   phase_type         frame_state  = PHASE_FIRST;
   logic [6:0]        first_hold   = '0;
   logic [5:0]        middle_hold  = '0;
   prefix_type        prefix_state = PFX_NONE;

   logic [WORD_W-1:0] pending_words [$];

   int  error_count   = 0;
   int  bytes_sent    = 0;
   int  words_checked = 0;
   int  mode_writes   = 0;
   int  cycle_count   = 0;
   int  hold_req      = 0;
   int  hold_seen     = 0;
   int  stall_left    = 0;
   bit  steady        = 1'b0;

   stim_row_type dir_rows [32] = '{
      '{ROW_MODE, 8'h00, 1'b0, '0},
      // a marked byte while waiting for a first byte is dropped
      '{ROW_BYTE, 8'h80, 1'b0, '0},
      '{ROW_BYTE, 8'h00, 1'b0, '0},
      '{ROW_BYTE, 8'h80, 1'b0, '0},
      '{ROW_BYTE, 8'hC0, 1'b1, 20'h00000},
      '{ROW_BYTE, 8'h7F, 1'b0, '0},
      '{ROW_BYTE, 8'hBF, 1'b0, '0},
      '{ROW_BYTE, 8'hFF, 1'b1, 20'h7FFFF},
      // restart at middle, then restart at last
      '{ROW_BYTE, 8'h12, 1'b0, '0},
      '{ROW_BYTE, 8'h34, 1'b0, '0},
      '{ROW_BYTE, 8'h85, 1'b0, '0},
      '{ROW_BYTE, 8'h55, 1'b0, '0},
      '{ROW_BYTE, 8'h8A, 1'b0, '0},
      '{ROW_BYTE, 8'hE5, 1'b0, '0},
      // wrong marked byte at middle, then at last
      '{ROW_BYTE, 8'h01, 1'b0, '0},
      '{ROW_BYTE, 8'hC1, 1'b0, '0},
      '{ROW_BYTE, 8'h02, 1'b0, '0},
      '{ROW_BYTE, 8'h81, 1'b0, '0},
      '{ROW_BYTE, 8'h82, 1'b0, '0},
      '{ROW_MODE, 8'h01, 1'b0, '0},
      '{ROW_BYTE, IAC_BYTE, 1'b0, '0},
      '{ROW_BYTE, IAC_BYTE, 1'b1, 20'h0007F},
      '{ROW_BYTE, {1'b0, ESC_CHAR}, 1'b0, '0},
      '{ROW_BYTE, {1'b0, ESC_CHAR}, 1'b0, '0},
      '{ROW_BYTE, 8'h41, 1'b1, ESC_WORD + 20'h41},
      '{ROW_BYTE, {1'b0, ESC_CHAR}, 1'b0, '0},
      '{ROW_BYTE, {1'b0, NUL_CHAR}, 1'b1, ESC_WORD},
      '{ROW_BYTE, {1'b0, NUL_CHAR}, 1'b1, DELAY_WORD},
      // IAC behind a pending escape is an ordinary character
      '{ROW_BYTE, {1'b0, ESC_CHAR}, 1'b0, '0},
      '{ROW_BYTE, IAC_BYTE, 1'b1, ESC_WORD + 20'h7F},
      '{ROW_BYTE, {1'b1, ESC_CHAR}, 1'b0, '0},
      '{ROW_BYTE, 8'h62, 1'b0, '0}
   };

   terminal_word_deframer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_term_word  (rsp_term_word),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_ascii_mode (csr_ascii_mode)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void deframe_byte(input logic [7:0] b, output bit hit,
                                        output logic [WORD_W-1:0] word);
      logic [6:0] c;
      bit         resync;
      hit    = 1'b0;
      word   = '0;
      c      = b[6:0];
      resync = 1'b1;
      if (!ascii_sel) begin
         case (frame_state)
            PHASE_MIDDLE: if (b[7:6] == SYNC_MID) begin
               middle_hold = b[5:0];
               frame_state = PHASE_LAST;
               resync      = 1'b0;
            end
            PHASE_LAST: if (b[7:6] == SYNC_LAST) begin
               hit         = 1'b1;
               word        = {1'b0, first_hold, middle_hold, b[5:0]};
               frame_state = PHASE_FIRST;
               resync      = 1'b0;
            end
            default: ;
         endcase
         if (resync) begin
            if (!b[7]) begin
               first_hold  = c;
               frame_state = PHASE_MIDDLE;
            end else begin
               frame_state = PHASE_FIRST;
            end
         end
      end else if (prefix_state == PFX_NONE && b == IAC_BYTE) begin
         prefix_state = PFX_IAC;
      end else if (c == ESC_CHAR) begin
         prefix_state = PFX_ESC;
      end else begin
         hit = 1'b1;
         if (prefix_state == PFX_ESC)
            word = ESC_WORD + WORD_W'(c);
         else if (c == NUL_CHAR)
            word = DELAY_WORD;
         else
            word = WORD_W'(c);
         prefix_state = PFX_NONE;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit known,
                            input logic [WORD_W-1:0] typed);
      bit                hit;
      logic [WORD_W-1:0] word;
      int unsigned       gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deframe_byte(b, hit, word);
      if (known)
         pending_words.push_back(typed);
      else if (hit)
         pending_words.push_back(word);
      bytes_sent++;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the input until every expected word is back and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      drain_results();
      csr_valid      <= 1'b1;
      csr_ascii_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ascii_sel = mode;
      mode_writes++;
   endtask

   task automatic send_framed_random();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         send_byte({1'b0, 7'($urandom)}, 1'b0, '0);
         send_byte({SYNC_MID, 6'($urandom)}, 1'b0, '0);
         send_byte({SYNC_LAST, 6'($urandom)}, 1'b0, '0);
      end else begin
         send_byte(8'($urandom), 1'b0, '0);
      end
   endtask

   task automatic send_ascii_random();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         send_byte({1'($urandom), 7'($urandom)}, 1'b0, '0);
      end else if (pick < 45) begin
         send_byte(IAC_BYTE, 1'b0, '0);
         send_byte(8'($urandom), 1'b0, '0);
      end else if (pick < 60) begin
         send_byte({1'($urandom), ESC_CHAR}, 1'b0, '0);
         send_byte(8'($urandom), 1'b0, '0);
      end else if (pick < 70) begin
         send_byte({1'($urandom), NUL_CHAR}, 1'b0, '0);
      end else if (pick < 80) begin
         send_byte(IAC_BYTE, 1'b0, '0);
         send_byte(IAC_BYTE, 1'b0, '0);
      end else begin
         send_byte(8'($urandom), 1'b0, '0);
      end
   endtask

   // result side: check each transfer, then stall at random or on request
   always @(posedge clock) begin
      logic [WORD_W-1:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               $error("term_word: unexpected transfer, got %h", rsp_term_word);
               error_count++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_term_word !== want) begin
                  $error("term_word: expected %h, got %h", want, rsp_term_word);
                  error_count++;
               end
               words_checked++;
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) rsp_ready <= 1'b1;
         end else if (hold_seen != hold_req) begin
            hold_seen  = hold_req;
            stall_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready && !steady) begin
            stall_left = $urandom_range(0, 3);
            if (stall_left != 0) rsp_ready <= 1'b0;
         end
      end
   end

   initial begin
      int target;
      bit mid_done;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_MODE)
            write_mode(dir_rows[i].value[0]);
         else
            send_byte(dir_rows[i].value, dir_rows[i].known, dir_rows[i].word);
      end

      for (int p = 0; p < PHASES; p++) begin
         write_mode(p < 4 ? p[0] : 1'($urandom));
         // p == 2: long output stall while bytes keep coming, to fill the pipe
         steady   <= (p == 5) || (p == 2);
         target   = bytes_sent + PHASE_BYTES;
         mid_done = 1'b0;
         if (p == 2) begin
            hold_req <= hold_req + 1;
         end
         while (bytes_sent < target) begin
            if (p == 2 && bytes_sent + PHASE_BYTES - 60 >= target) steady <= 1'b0;
            if (p == 3 && !mid_done && bytes_sent + PHASE_BYTES / 2 >= target) begin
               drain_results();
               mid_done = 1'b1;
            end
            if (ascii_sel)
               send_ascii_random();
            else
               send_framed_random();
         end
      end
      steady <= 1'b0;
      drain_results();

      $display("covered %0d bytes over both modes, %0d words checked, %0d mode writes",
               bytes_sent, words_checked, mode_writes);
      $display("included one long output stall and a full drain mid-stream");
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
